// ===== sv/tcw_pkg.sv =====
// shared constants, codes and controller/datapath types for the text console writer
package tcw_pkg;

   // default screen geometry
   localparam int COLS_DEFAULT = 80;
   localparam int ROWS_DEFAULT = 25;

   // field widths
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int RROW_W     = 5;
   localparam int RCOL_W     = 7;
   localparam int CELL_W     = 16;
   localparam int CROW_W     = 5;
   localparam int CCOL_W     = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam int FG_W       = 4;
   localparam int ATTR_W     = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // register reset values and indexes
   localparam logic [FG_W-1:0]      FG_RESET      = 4'd7;
   localparam logic [ATTR_W-1:0]    FILL_RESET    = 8'd112;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_ATTR = 4'd1;

   // tab stops every four columns
   localparam int TAB_BITS = 2;

   // write data source
   typedef enum logic [2:0] {
      W_BLANK       = 3'd0,
      W_RESET_BLANK = 3'd1,
      W_COPY        = 3'd2,
      W_CHAR        = 3'd3,
      W_SPACE       = 3'd4
   } wsrc_type;

   // write address source
   typedef enum logic [1:0] {
      A_CURSOR     = 2'd0,
      A_SWEEP      = 2'd1,
      A_SWEEP_PREV = 2'd2
   } asel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic     latch;
      logic     col_zero;
      logic     row_inc;
      logic     col_inc;
      logic     home;
      logic     sweep_clr;
      logic     sweep_inc;
      logic     mem_we;
      wsrc_type wsrc;
      asel_type asel;
      logic     rd_cell;
      logic     rd_copy;
      logic     set_scrolled;
      logic     load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_nul;
      logic            is_tab;
      logic            is_nl;
      logic            is_cr;
      logic            wrap_pend;
      logic            last_row;
      logic            tab_stop;
      logic            sweep_zero;
      logic            copy_end;
      logic            fill_end;
   } status_type;

endpackage

// ===== sv/tcw_if.sv =====
// channel interfaces for request, response and register write beats
interface tcw_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::OP_W-1:0]      op;
   logic [tcw_pkg::CHAR_W-1:0]    char_code;
   logic [tcw_pkg::RROW_W-1:0]    read_row;
   logic [tcw_pkg::RCOL_W-1:0]    read_col;

   modport source (output valid, op, char_code, read_row, read_col, input ready);
   modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcw_pkg::CELL_W-1:0]    cell_value;
   logic [tcw_pkg::CROW_W-1:0]    cursor_row;
   logic [tcw_pkg::CCOL_W-1:0]    cursor_col;
   logic                          scrolled;

   modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
   modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

interface tcw_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tcw_pkg::CSR_IDX_W-1:0]   index;
   logic [tcw_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/text_console_writer_core.sv =====
// top level of the character-cell text console writer
//
// Channels: req_bus takes one beat per item (op, char_code, read_row,
// read_col); rsp_bus returns exactly one beat per item (cell_value,
// cursor_row, cursor_col, scrolled); csr_bus writes fg_color (index 0) or
// fill_attr (index 1) and is always ready. Registers are to be written only
// while no item is in flight; the block itself does not enforce this.
// An ordinary character, return, newline without scroll, zero byte, read
// or unused op passes from accept through decode to a done state that
// loads the response register; a tab makes one screen write per padded
// space. A scroll and a clear walk every cell through the single write
// port of the screen store. Items are worked one at a time, so a new item
// is accepted only after the last one has loaded its response.
// Reset: registers return to fg_color 7 and fill_attr 112, the cursor homes
// and a clearing pass blanks all ROWS*COLS cells (2000 at 80x25);
// req_bus.ready stays low until it ends.
// Stall: the response sits in an output register while the next item is
// accepted and worked; that item waits for its response slot before
// finishing, so no beat is lost while rsp_bus.ready is low.
module text_console_writer_core #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_bus,
   tcw_rsp_if.source  rsp_bus,
   tcw_csr_if.sink    csr_bus
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   // register port never stalls
   assign csr_bus.ready = 1'b1;

   // controller
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   tcw_datapath #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_op         (req_bus.op),
      .req_char_code  (req_bus.char_code),
      .req_read_row   (req_bus.read_row),
      .req_read_col   (req_bus.read_col),
      .csr_we         (csr_bus.valid),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .rsp_cell_value (rsp_bus.cell_value),
      .rsp_cursor_row (rsp_bus.cursor_row),
      .rsp_cursor_col (rsp_bus.cursor_col),
      .rsp_scrolled   (rsp_bus.scrolled)
   );

endmodule

// ===== sv/tcw_datapath.sv =====
// screen store, cursor, sweep counter, registers and response register
module tcw_datapath #(
   parameter int COLS = tcw_pkg::COLS_DEFAULT,
   parameter int ROWS = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tcw_pkg::cmd_type                 cmd,
   output tcw_pkg::status_type              status,
   input  logic [tcw_pkg::OP_W-1:0]         req_op,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::RROW_W-1:0]       req_read_row,
   input  logic [tcw_pkg::RCOL_W-1:0]       req_read_col,
   input  logic                             csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [tcw_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic [tcw_pkg::CROW_W-1:0]       rsp_cursor_row,
   output logic [tcw_pkg::CCOL_W-1:0]       rsp_cursor_col,
   output logic                             rsp_scrolled
);

   localparam int CW     = $clog2(COLS + 1);
   localparam int RW     = $clog2(ROWS);
   localparam int DEPTH  = ROWS * COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int COPY_N = (ROWS - 1) * COLS;

   logic [tcw_pkg::FG_W-1:0]     fg_ff;
   logic [tcw_pkg::ATTR_W-1:0]   fill_ff;
   logic [RW-1:0]                row_ff;
   logic [CW-1:0]                col_ff;
   logic [AW-1:0]                sweep_ff;
   logic                         scr_ff;
   logic [tcw_pkg::OP_W-1:0]     op_ff;
   logic [tcw_pkg::CHAR_W-1:0]   ch_ff;
   logic [tcw_pkg::RROW_W-1:0]   rr_ff;
   logic [tcw_pkg::RCOL_W-1:0]   rc_ff;
   logic [tcw_pkg::CELL_W-1:0]   rd_ff;
   logic [tcw_pkg::CELL_W-1:0]   screen_ff [DEPTH];
   logic [tcw_pkg::CELL_W-1:0]   rsp_cell_ff;
   logic [tcw_pkg::CROW_W-1:0]   rsp_row_ff;
   logic [tcw_pkg::CCOL_W-1:0]   rsp_col_ff;
   logic                         rsp_scr_ff;

   logic [CW-1:0]                col_next;
   logic [AW-1:0]                cursor_addr;
   logic [AW-1:0]                cell_addr;
   logic                         cell_in_range;
   logic [AW-1:0]                waddr;
   logic [AW-1:0]                raddr;
   logic                         rd_en;
   logic [tcw_pkg::CELL_W-1:0]   wdata;

   // address arithmetic
   assign col_next      = col_ff + 1'b1;
   assign cursor_addr   = AW'(row_ff) * AW'(COLS) + AW'(col_ff);
   assign cell_addr     = AW'(rr_ff) * AW'(COLS) + AW'(rc_ff);
   assign cell_in_range = (int'(rr_ff) < ROWS) && (int'(rc_ff) < COLS);

   // status toward the controller
   always_comb begin
      status.op         = op_ff;
      status.is_nul     = ch_ff == tcw_pkg::CH_NUL;
      status.is_tab     = ch_ff == tcw_pkg::CH_TAB;
      status.is_nl      = ch_ff == tcw_pkg::CH_NL;
      status.is_cr      = ch_ff == tcw_pkg::CH_CR;
      status.wrap_pend  = col_ff == CW'(COLS);
      status.last_row   = row_ff == RW'(ROWS - 1);
      status.tab_stop   = (col_next[tcw_pkg::TAB_BITS-1:0] == '0) || (col_next == CW'(COLS));
      status.sweep_zero = sweep_ff == '0;
      status.copy_end   = sweep_ff == AW'(COPY_N);
      status.fill_end   = sweep_ff == AW'(DEPTH - 1);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff   <= tcw_pkg::FG_RESET;
         fill_ff <= tcw_pkg::FILL_RESET;
      end else if (csr_we) begin
         if (csr_index == tcw_pkg::CSR_FG_COLOR) begin
            fg_ff <= csr_data[tcw_pkg::FG_W-1:0];
         end
         if (csr_index == tcw_pkg::CSR_FILL_ATTR) begin
            fill_ff <= csr_data;
         end
      end
   end

   // cursor and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
         scr_ff   <= 1'b0;
      end else begin
         if (cmd.home) begin
            row_ff <= '0;
            col_ff <= '0;
         end else begin
            if (cmd.col_zero) begin
               col_ff <= '0;
            end else if (cmd.col_inc) begin
               col_ff <= col_next;
            end
            if (cmd.row_inc) begin
               row_ff <= row_ff + 1'b1;
            end
         end
         if (cmd.sweep_clr) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_inc) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (cmd.latch) begin
            scr_ff <= 1'b0;
         end else if (cmd.set_scrolled) begin
            scr_ff <= 1'b1;
         end
      end
   end

   // latched request beat
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_op;
         ch_ff <= req_char_code;
         rr_ff <= req_read_row;
         rc_ff <= req_read_col;
      end
   end

   // write address and data selection
   always_comb begin
      unique case (cmd.asel)
         tcw_pkg::A_SWEEP:      waddr = sweep_ff;
         tcw_pkg::A_SWEEP_PREV: waddr = sweep_ff - 1'b1;
         default:               waddr = cursor_addr;
      endcase
      unique case (cmd.wsrc)
         tcw_pkg::W_RESET_BLANK: wdata = {tcw_pkg::FILL_RESET, tcw_pkg::CH_SPACE};
         tcw_pkg::W_COPY:        wdata = rd_ff;
         tcw_pkg::W_CHAR:        wdata = {4'b0000, fg_ff, ch_ff};
         tcw_pkg::W_SPACE:       wdata = {4'b0000, fg_ff, tcw_pkg::CH_SPACE};
         default:                wdata = {fill_ff, tcw_pkg::CH_SPACE};
      endcase
   end

   assign rd_en = cmd.rd_copy || (cmd.rd_cell && cell_in_range);
   assign raddr = cmd.rd_copy ? (sweep_ff + AW'(COLS)) : cell_addr;

   // screen store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         screen_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= screen_ff[raddr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cell_ff <= (op_ff == tcw_pkg::OP_READ && cell_in_range) ? rd_ff : '0;
         rsp_row_ff  <= tcw_pkg::CROW_W'(row_ff);
         rsp_col_ff  <= tcw_pkg::CCOL_W'(col_ff);
         rsp_scr_ff  <= scr_ff;
      end
   end

   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   // writes stay inside the screen
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> int'(waddr) < DEPTH)
      else $error("screen write outside the store");

   // column never passes the pending-wrap position
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(COLS))
      else $error("cursor column beyond width");

   // scrolling only starts from the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      cmd.set_scrolled |-> row_ff == RW'(ROWS - 1))
      else $error("scroll started above the last row");

endmodule

// ===== sv/tcw_ctrl.sv =====
// controller state machine sequencing puts, scrolls, clears and reads
module tcw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tcw_pkg::status_type   status,
   output tcw_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_INIT   = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_DECODE = 9'b000000100,
      ST_TAB    = 9'b000001000,
      ST_PUT    = 9'b000010000,
      ST_COPY   = 9'b000100000,
      ST_BLANK  = 9'b001000000,
      ST_FILL   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   // what follows a scroll: nothing after a newline, the put or tab after a wrap
   typedef enum logic [1:0] {
      FOL_NONE = 2'd0,
      FOL_PUT  = 2'd1,
      FOL_TAB  = 2'd2
   } follow_type;

   state_type  state_ff, state_in;
   follow_type follow_ff, follow_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      follow_in = follow_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.mem_we = 1'b1;
            cmd.wsrc   = tcw_pkg::W_RESET_BLANK;
            cmd.asel   = tcw_pkg::A_SWEEP;
            if (status.fill_end) begin
               cmd.sweep_clr = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.sweep_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            unique case (status.op)
               tcw_pkg::OP_PUT: begin
                  if (status.is_nl) begin
                     cmd.col_zero = 1'b1;
                     if (status.last_row) begin
                        cmd.set_scrolled = 1'b1;
                        follow_in        = FOL_NONE;
                        state_in         = ST_COPY;
                     end else begin
                        cmd.row_inc = 1'b1;
                     end
                  end else if (status.is_cr) begin
                     cmd.col_zero = 1'b1;
                  end else if (!status.is_nul) begin
                     if (status.wrap_pend) begin
                        cmd.col_zero = 1'b1;
                        if (status.last_row) begin
                           cmd.set_scrolled = 1'b1;
                           follow_in        = status.is_tab ? FOL_TAB : FOL_PUT;
                           state_in         = ST_COPY;
                        end else begin
                           cmd.row_inc = 1'b1;
                           state_in    = status.is_tab ? ST_TAB : ST_PUT;
                        end
                     end else if (status.is_tab) begin
                        state_in = ST_TAB;
                     end else begin
                        cmd.mem_we  = 1'b1;
                        cmd.wsrc    = tcw_pkg::W_CHAR;
                        cmd.asel    = tcw_pkg::A_CURSOR;
                        cmd.col_inc = 1'b1;
                     end
                  end
               end
               tcw_pkg::OP_READ: begin
                  cmd.rd_cell = 1'b1;
               end
               tcw_pkg::OP_CLEAR: begin
                  state_in = ST_FILL;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_TAB: begin
            cmd.mem_we  = 1'b1;
            cmd.wsrc    = tcw_pkg::W_SPACE;
            cmd.asel    = tcw_pkg::A_CURSOR;
            cmd.col_inc = 1'b1;
            if (status.tab_stop) begin
               state_in = ST_DONE;
            end
         end
         ST_PUT: begin
            cmd.mem_we  = 1'b1;
            cmd.wsrc    = tcw_pkg::W_CHAR;
            cmd.asel    = tcw_pkg::A_CURSOR;
            cmd.col_inc = 1'b1;
            state_in    = ST_DONE;
         end
         ST_COPY: begin
            // read one row ahead, write the cell read in the previous cycle
            cmd.wsrc = tcw_pkg::W_COPY;
            cmd.asel = tcw_pkg::A_SWEEP_PREV;
            cmd.mem_we = 1'b1;
            if (status.copy_end) begin
               state_in = ST_BLANK;
            end else begin
               cmd.rd_copy   = 1'b1;
               cmd.sweep_inc = 1'b1;
               // nothing has been read yet on the first cycle
               cmd.mem_we    = !status.sweep_zero;
            end
         end
         ST_BLANK: begin
            cmd.mem_we = 1'b1;
            cmd.wsrc   = tcw_pkg::W_BLANK;
            cmd.asel   = tcw_pkg::A_SWEEP;
            if (status.fill_end) begin
               cmd.sweep_clr = 1'b1;
               unique case (follow_ff)
                  FOL_PUT: state_in = ST_PUT;
                  FOL_TAB: state_in = ST_TAB;
                  default: state_in = ST_DONE;
               endcase
            end else begin
               cmd.sweep_inc = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.mem_we = 1'b1;
            cmd.wsrc   = tcw_pkg::W_BLANK;
            cmd.asel   = tcw_pkg::A_SWEEP;
            if (status.fill_end) begin
               cmd.sweep_clr = 1'b1;
               cmd.home      = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.sweep_inc = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         follow_ff    <= FOL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         follow_ff    <= follow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // a loaded response is offered in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded response not offered");

   // every reset is followed by the clearing pass
   a_init_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> state_ff == ST_INIT)
      else $error("clearing pass skipped after reset");

endmodule
